// File: rtl/cba_pkg.sv
// Shared types and constants for the chunked bump allocator.
// No dependencies; imported by cba_mac, cba_ctrl, chunked_bump_allocator_top, cba_result_checker and testbench.
package cba_pkg;

	// Default values for the top-level parameters
	localparam int MAX_CHUNKS_DEF = 16;
	localparam int ADDR_BITS_DEF  = 32;

	// Field widths
	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 29;
	localparam int SHIFT_W = 4;
	localparam int CNT_W   = 5;
	localparam int ALIGN_W = 16;

	typedef enum logic [2:0] {
		OP_ALLOC        = 3'd0,
		OP_MARK         = 3'd1,
		OP_RET_SAVED    = 3'd2,
		OP_RET_GIVEN    = 3'd3,
		OP_CLEAR        = 3'd4,
		OP_CLEAR_CHUNKS = 3'd5,
		OP_BELONGS      = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TOO_BIG = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_IBASE = 2'd0,
		CFG_ICAP  = 2'd1,
		CFG_CBASE = 2'd2,
		CFG_CSIZE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		op_t                operation;
		logic [SIZE_W-1:0]  request_size;
		logic [SHIFT_W-1:0] align_shift;
		logic [ADDR_W-1:0]  given_marker;
		logic [ADDR_W-1:0]  query_address;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] block_address;
		status_t           status;
		logic              belongs;
		logic [ADDR_W-1:0] top_now;
		logic [ADDR_W-1:0] marker_now;
		logic [CNT_W-1:0]  chunks_open;
	} res_t;

	typedef struct packed {
		logic [ADDR_W-1:0] ibase;
		logic [SIZE_W-1:0] icap;
		logic [ADDR_W-1:0] cbase;
		logic [SIZE_W-1:0] csize;
	} cfg_t;

	// Width of the multiply-add result: product or base, plus one carry bit
	function automatic int mac_width(input int mult_w);
		int pw;
		pw = mult_w + SIZE_W;
		return ((pw > ADDR_W) ? pw : ADDR_W) + 1;
	endfunction

endpackage

// File: rtl/cba_mac.sv
// Shared multiply-add unit: sum = base + mult * chunk_size, registered.
// Depends on cba_pkg.
module cba_mac
	import cba_pkg::*;
#(
	parameter int MULT_W = $clog2(MAX_CHUNKS_DEF + 1)
) (
	input  logic                           clk,
	input  logic [ADDR_W-1:0]              base,
	input  logic [MULT_W-1:0]              mult,
	input  logic [SIZE_W-1:0]              csize,
	output logic [mac_width(MULT_W)-1:0]   sum_q
);

	localparam int PW = MULT_W + SIZE_W;
	localparam int RW = mac_width(MULT_W);

	logic [PW-1:0] prod;

	// Scale the chunk size by the chunk index
	assign prod = PW'(mult) * PW'(csize);

	// Add the region base and register
	always_ff @(posedge clk) begin
		sum_q <= RW'(base) + RW'(prod);
	end

endmodule

// File: rtl/cba_ctrl.sv
// Sequencer and allocator state for the chunked bump allocator.
// Depends on cba_pkg and the shared multiply-add unit cba_mac.
module cba_ctrl
	import cba_pkg::*;
#(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_stall,
	input  logic take,
	output logic done,
	output res_t result
);

	localparam int KW     = $clog2(MAX_CHUNKS + 1);
	localparam int RW     = mac_width(KW);
	localparam int MASK_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - MASK_W);
	localparam logic [KW-1:0] CHUNK_LIMIT = KW'(MAX_CHUNKS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_AL_INIT,
		S_AL_USED,
		S_AL_FIT,
		S_END,
		S_END_CHK,
		S_BEG,
		S_CADDR,
		S_FIN,
		S_RET_MUL,
		S_RET_CMP,
		S_BEL_CMP,
		S_EMIT
	} state_t;

	// Padding that lifts an address to the next multiple of the alignment
	function automatic logic [ALIGN_W-1:0] align_pad(
		input logic [ALIGN_W-1:0] low,
		input logic [ALIGN_W-1:0] amask
	);
		return (ALIGN_W'(0) - low) & amask;
	endfunction

	state_t             state_q;
	op_t                op_q;
	logic [SIZE_W-1:0]  size_q;
	logic [SHIFT_W-1:0] ash_q;
	logic [ADDR_W-1:0]  arg_q;
	logic [ADDR_W-1:0]  top_q;
	logic [ADDR_W-1:0]  marker_q;
	logic [KW-1:0]      open_q;
	logic [KW-1:0]      n_q;
	logic [SIZE_W-1:0]  used_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic [ADDR_W-1:0]  acc_q;
	logic [ADDR_W-1:0]  addr_q;
	status_t            status_q;
	logic               belongs_q;

	logic [ADDR_W-1:0]  mac_base;
	logic [KW-1:0]      mac_mult;
	logic [RW-1:0]      mac_res;

	logic [ALIGN_W-1:0] align_v;
	logic [ALIGN_W-1:0] pad;
	logic [SIZE_W:0]    need;
	logic               too_big;
	logic [ADDR_W-1:0]  init_off;
	logic [RW-1:0]      chunk_span;
	logic               before_ok;
	logic [SIZE_W-1:0]  room;
	logic               fits;
	logic [ADDR_W-1:0]  close_top;
	logic               m_lt_icap;
	logic               in_init;
	logic               in_chunk;
	logic               ret_stop;

	cba_mac #(
		.MULT_W(KW)
	) u_mac (
		.clk  (clk),
		.base (mac_base),
		.mult (mac_mult),
		.csize(cfg.csize),
		.sum_q(mac_res)
	);

	// Alignment, padding and request footprint
	assign align_v = ALIGN_W'((ALIGN_W + 1)'(1) << ash_q);
	assign pad     = align_pad(ptr_q[ALIGN_W-1:0], align_v - ALIGN_W'(1));
	assign need    = (SIZE_W + 1)'(size_q) + (SIZE_W + 1)'(align_v);
	assign too_big = need > (SIZE_W + 1)'(cfg.csize);

	// Initial region fit: new offset once padded and sized
	assign init_off = top_q + ADDR_W'(size_q) + ADDR_W'(pad);

	// Position inside the current chunk; mac_res holds its start offset
	assign chunk_span = RW'(top_q) - mac_res;
	assign before_ok  = (RW'(top_q) >= mac_res) && (chunk_span <= RW'(cfg.csize));
	assign room       = cfg.csize - used_q;
	assign fits       = (SIZE_W + 1)'(room) >= need;

	// Top after closing the overflow chunks
	always_comb begin
		close_top = top_q;
		if (top_q > ADDR_W'(cfg.icap)) begin
			close_top = (cfg.icap == '0) ? '0 : ADDR_W'(cfg.icap) - ADDR_W'(1);
		end
	end

	// Marker return: stop at the first chunk count that covers the distance
	assign m_lt_icap = arg_q < ADDR_W'(cfg.icap);
	assign ret_stop  = (mac_res >= RW'(ptr_q)) || (n_q == CHUNK_LIMIT);

	// Membership tests; mac_res holds the span of the open chunks
	assign in_init  = (arg_q >= cfg.ibase) &&
		((ADDR_W + 1)'(arg_q) < (ADDR_W + 1)'(cfg.ibase) + (ADDR_W + 1)'(cfg.icap));
	assign in_chunk = (cfg.csize != '0) && (arg_q >= cfg.cbase) &&
		(RW'(arg_q - cfg.cbase) < mac_res);

	// Select operands of the shared multiply-add
	always_comb begin
		mac_base = '0;
		mac_mult = '0;
		unique case (state_q)
			S_DISP: begin
				if (op_q == OP_BELONGS) begin
					mac_mult = open_q;
				end else begin
					mac_base = ADDR_W'(cfg.icap);
					mac_mult = open_q - KW'(1);
				end
			end
			S_RET_MUL: begin
				mac_mult = n_q;
			end
			S_END: begin
				mac_base = ADDR_W'(cfg.icap);
				mac_mult = n_q;
			end
			S_END_CHK: begin
				mac_base = ADDR_W'(cfg.icap);
				mac_mult = n_q - KW'(1);
			end
			S_BEG: begin
				mac_base = cfg.cbase;
				mac_mult = n_q - KW'(1);
			end
			default: ;
		endcase
	end

	// Sequencer, allocator state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_ALLOC;
			size_q    <= '0;
			ash_q     <= '0;
			arg_q     <= '0;
			top_q     <= '0;
			marker_q  <= '0;
			open_q    <= '0;
			n_q       <= '0;
			used_q    <= '0;
			ptr_q     <= '0;
			acc_q     <= '0;
			addr_q    <= '0;
			status_q  <= ST_OK;
			belongs_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q   <= cmd.operation;
						size_q <= cmd.request_size;
						ash_q  <= cmd.align_shift;
						if (cmd.operation == OP_RET_GIVEN) begin
							arg_q <= cmd.given_marker;
						end else if (cmd.operation == OP_RET_SAVED) begin
							arg_q <= marker_q;
						end else begin
							arg_q <= cmd.query_address;
						end
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					addr_q    <= '0;
					status_q  <= ST_OK;
					belongs_q <= 1'b0;
					state_q   <= S_EMIT;
					unique case (op_q)
						OP_ALLOC: begin
							if (top_q < ADDR_W'(cfg.icap)) begin
								ptr_q   <= cfg.ibase + top_q;
								state_q <= S_AL_INIT;
							end else if (open_q == '0) begin
								if (too_big) begin
									status_q <= ST_TOO_BIG;
								end else begin
									n_q     <= KW'(1);
									used_q  <= '0;
									state_q <= S_END;
								end
							end else begin
								n_q     <= open_q;
								state_q <= S_AL_USED;
							end
						end
						OP_MARK: begin
							marker_q <= top_q;
						end
						OP_RET_SAVED, OP_RET_GIVEN: begin
							if (m_lt_icap) begin
								open_q <= '0;
								top_q  <= arg_q;
							end else begin
								ptr_q   <= arg_q - ADDR_W'(cfg.icap);
								n_q     <= '0;
								state_q <= S_RET_MUL;
							end
						end
						OP_CLEAR: begin
							open_q <= '0;
							top_q  <= '0;
						end
						OP_CLEAR_CHUNKS: begin
							open_q <= '0;
							top_q  <= close_top;
						end
						OP_BELONGS: begin
							state_q <= S_BEL_CMP;
						end
						default: ;
					endcase
				end
				S_AL_INIT: begin
					if (init_off <= ADDR_W'(cfg.icap)) begin
						top_q   <= init_off;
						addr_q  <= (ptr_q + ADDR_W'(pad)) & ADDR_MASK;
						state_q <= S_EMIT;
					end else if (too_big) begin
						status_q <= ST_TOO_BIG;
						state_q  <= S_EMIT;
					end else begin
						n_q     <= KW'(1);
						used_q  <= '0;
						state_q <= S_END;
					end
				end
				S_AL_USED: begin
					used_q  <= before_ok ? chunk_span[SIZE_W-1:0] : cfg.csize;
					state_q <= S_AL_FIT;
				end
				S_AL_FIT: begin
					if (fits) begin
						state_q <= S_END;
					end else if (too_big) begin
						status_q <= ST_TOO_BIG;
						state_q  <= S_EMIT;
					end else if (n_q >= CHUNK_LIMIT) begin
						status_q <= ST_FULL;
						state_q  <= S_EMIT;
					end else begin
						n_q     <= n_q + KW'(1);
						used_q  <= '0;
						state_q <= S_END;
					end
				end
				S_END: begin
					state_q <= S_END_CHK;
				end
				S_END_CHK: begin
					// End of the target chunk must stay within 32-bit offsets
					if (mac_res[RW-1:ADDR_W] != '0) begin
						status_q <= ST_FULL;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_BEG;
					end
				end
				S_BEG: begin
					acc_q   <= mac_res[ADDR_W-1:0] + ADDR_W'(used_q) + ADDR_W'(size_q);
					state_q <= S_CADDR;
				end
				S_CADDR: begin
					ptr_q   <= mac_res[ADDR_W-1:0] + ADDR_W'(used_q);
					state_q <= S_FIN;
				end
				S_FIN: begin
					top_q   <= acc_q + ADDR_W'(pad);
					addr_q  <= (ptr_q + ADDR_W'(pad)) & ADDR_MASK;
					open_q  <= n_q;
					state_q <= S_EMIT;
				end
				S_RET_MUL: begin
					state_q <= S_RET_CMP;
				end
				S_RET_CMP: begin
					if (ret_stop) begin
						open_q  <= n_q;
						top_q   <= arg_q;
						state_q <= S_EMIT;
					end else begin
						n_q     <= n_q + KW'(1);
						state_q <= S_RET_MUL;
					end
				end
				S_BEL_CMP: begin
					belongs_q <= in_init || in_chunk;
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold off new commands until the current one is handed over
	assign cmd_stall = (state_q != S_IDLE);
	assign done      = (state_q == S_EMIT);

	assign result.block_address = addr_q;
	assign result.status        = status_q;
	assign result.belongs       = belongs_q;
	assign result.top_now       = top_q;
	assign result.marker_now    = marker_q;
	assign result.chunks_open   = CNT_W'(open_q);

endmodule

// File: rtl/chunked_bump_allocator_top.sv
// Chunked bump allocator: configuration registers, command sequencer and result register.
// Depends on cba_pkg and cba_ctrl.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the region registers;
//   it is always ready. The user must write it only while no command is in flight;
//   the block does not enforce this. cmd channel carries one command per beat,
//   taken when cmd_valid is high and cmd_stall is low. res channel returns exactly
//   one result beat per command, held while res_stall is high.
// Commands run through the sequencer one at a time. Marker set, clear, clear chunks,
//   the unused code, membership queries and allocations inside the initial region
//   take short paths; an allocation in an overflow chunk passes through more states,
//   and a marker return steps through the chunk counts one by one, up to MAX_CHUNKS,
//   on the shared multiply-add unit until one covers the marker.
// The result register frees the sequencer: the next command is taken while a
// result still waits; a further result waits in the sequencer until the
// register drains.
// Reset clears the top offset, marker and chunk count and loads the register
// defaults (both sizes 65536, both bases 0).
module chunked_bump_allocator_top
	import cba_pkg::*;
#(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_t              cmd_data,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res_data
);

	cfg_t cfg_q;
	logic res_valid_q;
	res_t res_q;
	logic done;
	logic take;
	res_t result;

	cba_ctrl #(
		.MAX_CHUNKS(MAX_CHUNKS),
		.ADDR_BITS (ADDR_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd_data),
		.cmd_stall(cmd_stall),
		.take     (take),
		.done     (done),
		.result   (result)
	);

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ibase <= '0;
			cfg_q.icap  <= SIZE_W'(65536);
			cfg_q.cbase <= '0;
			cfg_q.csize <= SIZE_W'(65536);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IBASE: cfg_q.ibase <= cfg_data;
				CFG_ICAP:  cfg_q.icap  <= cfg_data[SIZE_W-1:0];
				CFG_CBASE: cfg_q.cbase <= cfg_data;
				CFG_CSIZE: cfg_q.csize <= cfg_data[SIZE_W-1:0];
			endcase
		end
	end

	// Load the result register when it is empty or draining this cycle
	assign take = done && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Hold the result beat while stalled
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// File: dv/cba_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the chunked bump allocator: follows register writes and
// command beats, predicts every result beat and compares it field by field.
// Depends on cba_pkg; instantiated beside the block by the testbench top.
module cba_result_checker
	import cba_pkg::*;
#(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [ADDR_W-1:0] cfg_data,
	input  logic              cmd_valid,
	input  logic              cmd_stall,
	input  cmd_t              cmd_data,
	input  logic              res_valid,
	input  logic              res_stall,
	input  res_t              res_data,
	output int                failures,
	output int                owed_count
);

	localparam logic [63:0] TOP_LIMIT = 64'hFFFF_FFFF;

	// Region registers and allocator state, widened so no sum can wrap
	logic [63:0] ibase, icap, cbase, csize;
	logic [63:0] top, marker, nopen;
	res_t owed_results[$];
	res_t oldest;

	function automatic logic [63:0] round_up(input logic [63:0] x, input logic [63:0] a);
		return (x + a - 64'd1) & ~(a - 64'd1);
	endfunction

	// Close every chunk; pull a top that lies in the chunks back into the initial region
	function automatic void drop_chunks();
		nopen = 0;
		if (top > icap)
			top = (icap != 0) ? icap - 64'd1 : 64'd0;
	endfunction

	// Move top to a marker and keep open only the chunks that the marker reaches into
	function automatic void rewind(input logic [63:0] m);
		logic [63:0] d, keep;
		if (m < icap) begin
			drop_chunks();
		end else begin
			d = m - icap;
			if (csize == 0)
				keep = (d != 0) ? MAX_CHUNKS : 0;
			else
				keep = d / csize + ((d % csize) != 0);
			if (keep > MAX_CHUNKS)
				keep = MAX_CHUNKS;
			nopen = keep;
		end
		top = m & TOP_LIMIT;
	endfunction

	// Apply one command to the allocator state and return the result it yields
	function automatic res_t predict(input cmd_t c);
		res_t r;
		logic [63:0] size, a, q, n, used, start, caddr, ptr;
		logic in_chunk;
		r = '0;
		size = c.request_size;
		a = 64'd1 << c.align_shift;
		q = c.query_address;
		n = 0;
		used = 0;
		in_chunk = 1'b0;
		case (c.operation)
			OP_ALLOC: begin
				if (top < icap) begin
					// try the initial region first, then fall over to chunk zero
					ptr = round_up(ibase + top, a);
					if (ptr + size - ibase <= icap) begin
						top = ptr + size - ibase;
						r.block_address = ptr[31:0];
					end else if (size + a > csize) begin
						r.status = ST_TOO_BIG;
					end else begin
						n = 1;
						in_chunk = 1'b1;
					end
				end else begin
					// a chunk position that makes no sense counts as a full chunk
					n = nopen;
					used = csize;
					if (n != 0) begin
						start = icap + (n - 64'd1) * csize;
						if (top >= start && top - start <= csize)
							used = top - start;
					end
					in_chunk = 1'b1;
					if (n == 0 || csize - used < size + a) begin
						if (size + a > csize) begin
							r.status = ST_TOO_BIG;
							in_chunk = 1'b0;
						end else if (n >= MAX_CHUNKS) begin
							r.status = ST_FULL;
							in_chunk = 1'b0;
						end else begin
							n = n + 64'd1;
							used = 0;
						end
					end
				end
				if (in_chunk) begin
					// a chunk ending past the 32-bit offset range is unavailable
					if (icap + n * csize > TOP_LIMIT) begin
						r.status = ST_FULL;
					end else begin
						caddr = cbase + (n - 64'd1) * csize;
						ptr = round_up(caddr + used, a);
						top = icap + (n - 64'd1) * csize + (ptr - caddr) + size;
						nopen = n;
						r.block_address = ptr[31:0];
					end
				end
			end
			OP_MARK:         marker = top;
			OP_RET_SAVED:    rewind(marker);
			OP_RET_GIVEN:    rewind(c.given_marker);
			OP_CLEAR: begin
				nopen = 0;
				top = 0;
			end
			OP_CLEAR_CHUNKS: drop_chunks();
			OP_BELONGS:
				r.belongs = (q >= ibase && q < ibase + icap) ||
					(csize != 0 && q >= cbase && (q - cbase) / csize < nopen);
			default: ;
		endcase
		r.top_now = top[31:0];
		r.marker_now = marker[31:0];
		r.chunks_open = nopen[CNT_W-1:0];
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			failures++;
		end
	endfunction

	// Track register writes, queue predictions per command beat, match result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibase = 0;
			icap = 65536;
			cbase = 0;
			csize = 65536;
			top = 0;
			marker = 0;
			nopen = 0;
			failures = 0;
			owed_results.delete();
			owed_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IBASE: ibase = cfg_data;
					CFG_ICAP:  icap = cfg_data[SIZE_W-1:0];
					CFG_CBASE: cbase = cfg_data;
					default:   csize = cfg_data[SIZE_W-1:0];
				endcase
			end
			if (res_valid && !res_stall) begin
				if (owed_results.size() == 0) begin
					$error("result beat with no command outstanding: block_address %0h",
						res_data.block_address);
					failures++;
				end else begin
					oldest = owed_results.pop_front();
					check_field("block_address", oldest.block_address, res_data.block_address);
					check_field("status", oldest.status, res_data.status);
					check_field("belongs", oldest.belongs, res_data.belongs);
					check_field("top_now", oldest.top_now, res_data.top_now);
					check_field("marker_now", oldest.marker_now, res_data.marker_now);
					check_field("chunks_open", oldest.chunks_open, res_data.chunks_open);
				end
			end
			if (cmd_valid && !cmd_stall)
				owed_results.push_back(predict(cmd_data));
			owed_count <= owed_results.size();
		end
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the chunked bump allocator: drives configuration and
// command beats with bursty idling, stalls results, and gives the verdict.
// Depends on cba_pkg, chunked_bump_allocator_top and cba_result_checker.
module testbench;
	import cba_pkg::*;

	localparam op_t OP_SPARE   = op_t'(3'd7);
	localparam int  REQ_MAX    = 1 << 28;
	localparam int  PHASES     = 7;
	localparam int  PHASE_ITEMS = 147;
	localparam int  STALL_LIMIT = 2000;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [1:0]        cfg_index = CFG_IBASE;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic              cmd_valid = 1'b0;
	cmd_t              cmd_data = '0;
	logic              res_stall = 1'b0;
	logic              cfg_ready, cmd_stall, res_valid;
	res_t              res_data;

	int          failures, owed_count;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          mode_left = 0;
	rx_mode_t    rx_mode = RX_FREE;
	int unsigned ibase_now = 0, icap_now = 65536, cbase_now = 0, csize_now = 65536;

	chunked_bump_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	cba_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_data   (cmd_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.failures   (failures),
		.owed_count (owed_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall results on a pattern that changes mode at random intervals
	always @(posedge clk) begin
		if (mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(8, 80);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (rx_mode)
			RX_FREE:  res_stall <= 1'b0;
			RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
			default:  res_stall <= mode_left[2];
		endcase
	end

	// Drop the run when no beat moves on any channel for too long
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(input op_t op, input logic [SIZE_W-1:0] size,
			input logic [SHIFT_W-1:0] shift, input logic [ADDR_W-1:0] given,
			input logic [ADDR_W-1:0] query);
		cmd_t c;
		c.operation = op;
		c.request_size = size;
		c.align_shift = shift;
		c.given_marker = given;
		c.query_address = query;
		return c;
	endfunction

	// Mostly allocations sized against the current chunk, mixed with marker work
	function automatic cmd_t random_cmd();
		cmd_t c;
		int unsigned pick, hi;
		c = make_cmd(OP_ALLOC, $urandom_range(0, REQ_MAX), $urandom_range(0, 12),
			$urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			hi = csize_now + 8;
			if (hi > REQ_MAX)
				hi = REQ_MAX;
			case ($urandom_range(0, 9))
				0:       c.request_size = 0;
				1:       c.request_size = $urandom_range(0, REQ_MAX);
				2, 3:    c.request_size = $urandom_range(csize_now / 2, hi);
				default: c.request_size = $urandom_range(0, csize_now / 8 + 2);
			endcase
			if ($urandom_range(0, 3) != 0)
				c.align_shift = $urandom_range(0, 3);
		end else if (pick < 63) begin
			c.operation = OP_MARK;
		end else if (pick < 70) begin
			c.operation = OP_RET_SAVED;
		end else if (pick < 78) begin
			c.operation = OP_RET_GIVEN;
			case ($urandom_range(0, 3))
				0:       c.given_marker = $urandom;
				1:       c.given_marker = $urandom_range(0, icap_now);
				default: c.given_marker = icap_now + $urandom_range(0, 17) * csize_now +
					$urandom_range(0, 2) - 1;
			endcase
		end else if (pick < 81) begin
			c.operation = OP_CLEAR;
		end else if (pick < 85) begin
			c.operation = OP_CLEAR_CHUNKS;
		end else if (pick < 98) begin
			c.operation = OP_BELONGS;
			case ($urandom_range(0, 3))
				0:       c.query_address = $urandom;
				1:       c.query_address = ibase_now + $urandom_range(0, icap_now + 1) - 1;
				default: c.query_address = cbase_now + $urandom_range(0, 16) * csize_now +
					$urandom_range(0, csize_now) - 1;
			endcase
		end else begin
			c.operation = OP_SPARE;
		end
		return c;
	endfunction

	// Send one command beat; open a new burst after a random gap when one runs out
	task automatic issue(input cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd_data <= c;
		do @(posedge clk); while (cmd_stall);
	endtask

	// Hold off commands until every predicted result has been taken
	task automatic settle();
		cmd_valid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (owed_count != 0) @(posedge clk);
	endtask

	// Write all four region registers back to back
	task automatic configure(input logic [31:0] ib, input logic [31:0] ic,
			input logic [31:0] cb, input logic [31:0] cs);
		cfg_reg_t r;
		r = r.first();
		cfg_valid <= 1'b1;
		do begin
			cfg_index <= r;
			case (r)
				CFG_IBASE: cfg_data <= ib;
				CFG_ICAP:  cfg_data <= ic;
				CFG_CBASE: cfg_data <= cb;
				default:   cfg_data <= cs;
			endcase
			do @(posedge clk); while (!cfg_ready);
			r = r.next();
		end while (r != r.first());
		cfg_valid <= 1'b0;
		ibase_now = ib;
		icap_now = ic;
		cbase_now = cb;
		csize_now = cs;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk on the reset region layout
		issue(make_cmd(OP_BELONGS, 0, 0, $urandom, 32'h0));
		issue(make_cmd(OP_ALLOC, 0, 0, $urandom, $urandom));
		issue(make_cmd(OP_ALLOC, 100, 12, $urandom, $urandom));
		issue(make_cmd(OP_MARK, 0, 0, 0, 0));
		// spill out of the initial region into chunk zero
		issue(make_cmd(OP_ALLOC, 65000, 3, $urandom, $urandom));
		issue(make_cmd(OP_ALLOC, REQ_MAX, 12, $urandom, $urandom));
		issue(make_cmd(OP_ALLOC, 500, 4, 0, 0));
		issue(make_cmd(OP_ALLOC, 600, 0, 0, 0));
		issue(make_cmd(OP_BELONGS, 0, 0, 0, 32'hFFFF_FFFF));
		issue(make_cmd(OP_RET_SAVED, 0, 0, $urandom, $urandom));
		// marker far past the chunks: count saturates, chunk position is nonsense
		issue(make_cmd(OP_RET_GIVEN, 0, 0, 32'hFFFF_FFFF, 0));
		issue(make_cmd(OP_ALLOC, 1, 0, 0, 0));
		issue(make_cmd(OP_BELONGS, 0, 0, 0, 32'h000F_FFFF));
		issue(make_cmd(OP_CLEAR_CHUNKS, 0, 0, 0, 0));
		issue(make_cmd(OP_ALLOC, 1, 0, 0, 0));
		// top at the region end with no chunk open
		issue(make_cmd(OP_RET_GIVEN, 0, 0, 32'd65536, 0));
		issue(make_cmd(OP_ALLOC, 10, 1, 0, 0));
		issue(make_cmd(OP_RET_GIVEN, 0, 0, 32'd262149, 0));
		issue(make_cmd(OP_ALLOC, 65535, 0, 0, 0));
		issue(make_cmd(OP_MARK, 0, 0, 0, 0));
		issue(make_cmd(OP_CLEAR, 0, 0, 0, 0));
		issue(make_cmd(OP_SPARE, $urandom_range(0, REQ_MAX), 12, $urandom, $urandom));
		issue(make_cmd(OP_RET_GIVEN, 0, 0, 32'h0, 0));
		issue(make_cmd(OP_ALLOC, 8, 8, 0, 0));
		settle();

		// Random phases, each on its own region layout, extremes first
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: configure(32'h0000_1000, 256, 32'h0001_0000, 256);
				1: configure(32'hFFFF_FF00, 0, 32'hFFFF_F000, 1);
				2: configure(32'h0, REQ_MAX, 32'hF000_0000, REQ_MAX);
				3: configure(32'hFFFF_FFFF, 4096, 32'h0, 4096);
				4: configure($urandom, $urandom_range(0, 1 << 20), $urandom,
					$urandom_range(1, 1 << 16));
				5: configure($urandom, 1, $urandom, REQ_MAX);
				default: configure($urandom, $urandom_range(0, 1 << 16), $urandom,
					$urandom_range(1, 1 << 12));
			endcase
			repeat (PHASE_ITEMS) issue(random_cmd());
			settle();
		end

		repeat (40) @(posedge clk);
		if (failures == 0 && owed_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
